// ===== sv/mcam_pkg.sv =====
// Shared constants and codes for the multi-channel alarm manager.
// No dependencies; imported by multi_channel_alarm_manager.
package mcam_pkg;

    localparam int CHANNELS = 4;          // channels in use, 1 to 4
    localparam int LANES    = 4;          // limit lanes per 64-bit limit word
    localparam int LANE_W   = 16;         // Q8.8 limit width

    // Alarm levels
    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_WARN  = 2'd1;
    localparam logic [1:0] LVL_ALARM = 2'd2;
    localparam logic [1:0] LVL_TECH  = 2'd3;

    // Request kinds carried in s_axis_tuser
    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_SET_TECH  = 2'd1,
        REQ_CLR_TECH  = 2'd2,
        REQ_ACK       = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ENABLE    = 3'd0,
        CFG_AUTO_RST  = 3'd1,
        CFG_ALARM_LO  = 3'd2,
        CFG_ALARM_HI  = 3'd3,
        CFG_WARN_LO   = 3'd4,
        CFG_WARN_HI   = 3'd5
    } t_cfg_reg;

endpackage

// ===== sv/multi_channel_alarm_manager.sv =====
// Multi-channel alarm manager: per-channel alarm state, limit checks and LED masks.
// Depends on mcam_pkg.
//
// Usage
//   Request channel (s_axis_*): one transaction is one request. tuser carries the
//   request kind (process sample, set technical, clear technical, acknowledge);
//   tdata carries channel, Q8.8 sample, fault code and the millisecond time.
//   Result channel (m_axis_*): exactly one transaction per request. tuser flags
//   whether the channel index was in range; tdata holds the addressed channel's
//   level, flags, error code and raise time plus the warning-LED, alarm-LED and
//   output-enable masks of all channels, taken after the request is applied.
//   Configuration channel (i_cfg_*): register index and 64-bit data, always ready;
//   indexes six and seven are accepted and dropped. Write only while idle.
// Timing
//   A request is captured in an input register and resolved in one pass of
//   compare and update logic into the result register once that register is
//   free or being read. One request per cycle is sustained while m_axis_tready
//   stays high; the rate is set by that single input-to-result stage.
// Reset and stall
//   Synchronous active-low reset clears all limits, masks and channel state.
//   While the receiver holds m_axis_tready low the result is held, the input
//   register takes one more request, then s_axis_tready drops until it drains.
module multi_channel_alarm_manager
    import mcam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] channel, [18:3] sample, [26:19] fault_code, [58:27] now_ms, [63:59] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] level, [2] is_active, [3] is_acked, [11:4] error_out,
    // [43:12] raised_at_ms, [47:44] warning_leds, [51:48] alarm_leds,
    // [55:52] output_enables
    output logic [55:0] m_axis_tdata,
    // [0] index_ok
    output logic [0:0]  m_axis_tuser,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers
    logic [3:0]  r_en_mask;
    logic [3:0]  r_auto_mask;
    logic [63:0] r_alarm_lo;
    logic [63:0] r_alarm_hi;
    logic [63:0] r_warn_lo;
    logic [63:0] r_warn_hi;

    // Channel state
    logic [1:0]  r_level   [CHANNELS];
    logic [7:0]  r_error   [CHANNELS];
    logic [31:0] r_raised  [CHANNELS];
    logic        r_active  [CHANNELS];
    logic        r_acked   [CHANNELS];

    logic [1:0]  n_level   [CHANNELS];
    logic [7:0]  n_error   [CHANNELS];
    logic [31:0] n_raised  [CHANNELS];
    logic        n_active  [CHANNELS];
    logic        n_acked   [CHANNELS];

    // Input register
    logic               r_in_vld;
    t_req               r_in_req;
    logic [2:0]         r_in_chan;
    logic signed [15:0] r_in_sample;
    logic [7:0]         r_in_code;
    logic [31:0]        r_in_now;

    // Result register
    logic        r_out_vld;
    logic [55:0] r_out_data;
    logic        r_out_ok;

    logic        adv;
    logic        ok;
    logic [1:0]  ch;
    logic [1:0]  smp_lvl;
    logic signed [15:0] lim_al, lim_ah, lim_wl, lim_wh;
    logic [3:0]  n_wl, n_al, n_oe;
    logic [55:0] n_out_data;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ok;
    assign o_cfg_ready   = 1'b1;

    assign ok = (r_in_chan < 3'(CHANNELS));
    assign ch = r_in_chan[1:0];

    // Limits of the addressed lane
    assign lim_al = r_alarm_lo[{ch, 4'h0} +: LANE_W];
    assign lim_ah = r_alarm_hi[{ch, 4'h0} +: LANE_W];
    assign lim_wl = r_warn_lo[{ch, 4'h0} +: LANE_W];
    assign lim_wh = r_warn_hi[{ch, 4'h0} +: LANE_W];

    always_comb begin
        if (r_in_sample <= lim_al || r_in_sample >= lim_ah) begin
            smp_lvl = LVL_ALARM;
        end else if (r_in_sample <= lim_wl || r_in_sample >= lim_wh) begin
            smp_lvl = LVL_WARN;
        end else begin
            smp_lvl = LVL_NONE;
        end
    end

    // State update for the addressed channel
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_level[c]  = r_level[c];
            n_error[c]  = r_error[c];
            n_raised[c] = r_raised[c];
            n_active[c] = r_active[c];
            n_acked[c]  = r_acked[c];
        end
        if (ok) begin
            case (r_in_req)
                REQ_SAMPLE: begin
                    if (r_en_mask[ch]) begin
                        if (smp_lvl > r_level[ch]) begin
                            n_level[ch]  = smp_lvl;
                            n_error[ch]  = 8'd0;
                            n_raised[ch] = r_in_now;
                            n_active[ch] = 1'b1;
                            n_acked[ch]  = 1'b0;
                        end else if (smp_lvl < r_level[ch] && r_auto_mask[ch]) begin
                            n_level[ch]  = smp_lvl;
                            n_active[ch] = (smp_lvl != LVL_NONE);
                        end
                    end
                end
                REQ_SET_TECH: begin
                    n_level[ch]  = LVL_TECH;
                    n_error[ch]  = r_in_code;
                    n_raised[ch] = r_in_now;
                    n_active[ch] = 1'b1;
                    n_acked[ch]  = 1'b0;
                end
                REQ_CLR_TECH: begin
                    if (r_level[ch] == LVL_TECH) begin
                        n_active[ch] = 1'b0;
                        if (r_auto_mask[ch]) begin
                            n_level[ch] = LVL_NONE;
                            n_error[ch] = 8'd0;
                        end
                    end
                end
                REQ_ACK: begin
                    n_acked[ch] = 1'b1;
                    if (!r_auto_mask[ch] && !r_active[ch]) begin
                        n_level[ch] = LVL_NONE;
                        n_error[ch] = 8'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Masks over the updated state; unused channel bits stay zero
    always_comb begin
        n_wl = 4'd0;
        n_al = 4'd0;
        n_oe = 4'd0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (n_active[c] && !n_acked[c]) begin
                n_wl[c] = (n_level[c] == LVL_WARN);
                n_al[c] = (n_level[c] >= LVL_ALARM);
            end
            n_oe[c] = (n_level[c] <= LVL_WARN);
        end
    end

    always_comb begin
        n_out_data = '0;
        if (ok) begin
            n_out_data[1:0]   = n_level[ch];
            n_out_data[2]     = n_active[ch];
            n_out_data[3]     = n_acked[ch];
            n_out_data[11:4]  = n_error[ch];
            n_out_data[43:12] = n_raised[ch];
        end
        n_out_data[47:44] = n_wl;
        n_out_data[51:48] = n_al;
        n_out_data[55:52] = n_oe;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_mask   <= '0;
            r_auto_mask <= '0;
            r_alarm_lo  <= '0;
            r_alarm_hi  <= '0;
            r_warn_lo   <= '0;
            r_warn_hi   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE:   r_en_mask   <= i_cfg_data[3:0];
                CFG_AUTO_RST: r_auto_mask <= i_cfg_data[3:0];
                CFG_ALARM_LO: r_alarm_lo  <= i_cfg_data;
                CFG_ALARM_HI: r_alarm_hi  <= i_cfg_data;
                CFG_WARN_LO:  r_warn_lo   <= i_cfg_data;
                CFG_WARN_HI:  r_warn_hi   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Channel state, committed when the request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_level[c]  <= LVL_NONE;
                r_error[c]  <= '0;
                r_raised[c] <= '0;
                r_active[c] <= 1'b0;
                r_acked[c]  <= 1'b0;
            end
        end else if (adv) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_level[c]  <= n_level[c];
                r_error[c]  <= n_error[c];
                r_raised[c] <= n_raised[c];
                r_active[c] <= n_active[c];
                r_acked[c]  <= n_acked[c];
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req    <= t_req'(s_axis_tuser);
            r_in_chan   <= s_axis_tdata[2:0];
            r_in_sample <= s_axis_tdata[18:3];
            r_in_code   <= s_axis_tdata[26:19];
            r_in_now    <= s_axis_tdata[58:27];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
            r_out_ok   <= ok;
        end
    end

    // A channel at level none never reports an active condition
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
        a_none_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_level[c] == LVL_NONE) |-> !r_active[c])
            else $error("channel at level none is active");
    end

    // A lit alarm LED means a level above warning, so that channel's output is off
    a_led_vs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_data[51:48] & r_out_data[55:52]) == 4'd0 &&
                       (r_out_data[47:44] & r_out_data[51:48]) == 4'd0))
        else $error("alarm LED set on an enabled or warning channel");

    // Out-of-range requests report zeroed channel fields
    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_ok) |-> (r_out_data[43:0] == 44'd0))
        else $error("out-of-range result carries channel fields");

    // Each committed request produces a pending result on the next edge
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("committed request lost its result");

endmodule

// ===== bench/multi_channel_alarm_manager_tb.sv =====
// Self-checking bench for multi_channel_alarm_manager: directed and random requests,
// with every result compared against an in-bench prediction of the per-channel alarm state.
// Depends on mcam_pkg and multi_channel_alarm_manager.
module multi_channel_alarm_manager_tb
    import mcam_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One request as the bench sees it, before packing onto the stream
    typedef struct packed {
        t_req               kind;
        logic [2:0]         chan;
        logic [15:0]        smp;    // signed Q8.8
        logic [7:0]         code;
        logic [31:0]        now;
    } t_req_item;

    // One result, field by field
    typedef struct packed {
        logic               ok;
        logic [1:0]         level;
        logic               active;
        logic               acked;
        logic [7:0]         err;
        logic [31:0]        raised;
        logic [3:0]         wled;
        logic [3:0]         aled;
        logic [3:0]         oe;
    } t_alarm_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    multi_channel_alarm_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Bench copy of the configuration registers
    logic [3:0]  en_mask;
    logic [3:0]  auto_mask;
    logic [63:0] alarm_lo_w;
    logic [63:0] alarm_hi_w;
    logic [63:0] warn_lo_w;
    logic [63:0] warn_hi_w;

    // Bench copy of the per-channel alarm state
    logic [1:0]  chan_level  [4];
    logic [7:0]  chan_error  [4];
    logic [31:0] chan_raised [4];
    logic        chan_active [4];
    logic        chan_acked  [4];

    t_req_item      pending_requests [$];   // waiting for the driver
    t_alarm_result  expected_results [$];   // predicted, waiting for the monitor
    t_req_item      on_wire;                // request currently offered on the slave side
    logic           req_taken = 1'b0;       // request transaction at the last rising edge

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int results_seen   = 0;
    logic [31:0] ms_clock = '0;
    logic [2:0]  focus_chan = '0;

    // Clock and timeout
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Signed Q8.8 limit of one channel out of a packed 64-bit limit word
    function automatic logic signed [15:0] lane_of(logic [63:0] words, int ch);
        return words[16*ch +: 16];
    endfunction

    // Applies one request to the bench state and returns the result it should yield
    function automatic t_alarm_result resolve_request(t_req_item r);
        t_alarm_result res;
        logic [1:0] lvl;
        logic autor;
        int ch;
        res = '0;
        ch = int'(r.chan);
        if (r.chan < CHANNELS) begin
            autor = auto_mask[ch];
            case (r.kind)
                REQ_SAMPLE: begin
                    // disabled channel: sample is simply dropped
                    if (en_mask[ch]) begin
                        if ($signed(r.smp) <= lane_of(alarm_lo_w, ch) ||
                            $signed(r.smp) >= lane_of(alarm_hi_w, ch))
                            lvl = LVL_ALARM;
                        else if ($signed(r.smp) <= lane_of(warn_lo_w, ch) ||
                                 $signed(r.smp) >= lane_of(warn_hi_w, ch))
                            lvl = LVL_WARN;
                        else
                            lvl = LVL_NONE;
                        if (lvl > chan_level[ch]) begin
                            chan_level[ch]  = lvl;
                            chan_error[ch]  = '0;
                            chan_raised[ch] = r.now;
                            chan_active[ch] = 1'b1;
                            chan_acked[ch]  = 1'b0;
                        end else if (lvl < chan_level[ch] && autor) begin
                            chan_level[ch]  = lvl;
                            chan_active[ch] = (lvl != LVL_NONE);
                        end
                    end
                end
                REQ_SET_TECH: begin
                    chan_level[ch]  = LVL_TECH;
                    chan_error[ch]  = r.code;
                    chan_raised[ch] = r.now;
                    chan_active[ch] = 1'b1;
                    chan_acked[ch]  = 1'b0;
                end
                REQ_CLR_TECH: begin
                    if (chan_level[ch] == LVL_TECH) begin
                        chan_active[ch] = 1'b0;
                        if (autor) begin
                            chan_level[ch] = LVL_NONE;
                            chan_error[ch] = '0;
                        end
                    end
                end
                default: begin
                    chan_acked[ch] = 1'b1;
                    if (!autor && !chan_active[ch]) begin
                        chan_level[ch] = LVL_NONE;
                        chan_error[ch] = '0;
                    end
                end
            endcase
            res.ok     = 1'b1;
            res.level  = chan_level[ch];
            res.active = chan_active[ch];
            res.acked  = chan_acked[ch];
            res.err    = chan_error[ch];
            res.raised = chan_raised[ch];
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (chan_active[i] && !chan_acked[i]) begin
                if (chan_level[i] == LVL_WARN)
                    res.wled[i] = 1'b1;
                else if (chan_level[i] >= LVL_ALARM)
                    res.aled[i] = 1'b1;
            end
            if (chan_level[i] <= LVL_WARN)
                res.oe[i] = 1'b1;
        end
        return res;
    endfunction

    task automatic log_mismatch(string what, logic [63:0] want, logic [63:0] seen);
        error_count++;
        if (error_count <= 10)
            $display("result %0d: %s expected %0h got %0h", results_seen, what, want, seen);
    endtask

    task automatic compare_result(t_alarm_result seen, t_alarm_result want);
        if (seen.ok     !== want.ok)
            log_mismatch("index_ok",       64'(want.ok),     64'(seen.ok));
        if (seen.level  !== want.level)
            log_mismatch("level",          64'(want.level),  64'(seen.level));
        if (seen.active !== want.active)
            log_mismatch("is_active",      64'(want.active), 64'(seen.active));
        if (seen.acked  !== want.acked)
            log_mismatch("is_acked",       64'(want.acked),  64'(seen.acked));
        if (seen.err    !== want.err)
            log_mismatch("error_out",      64'(want.err),    64'(seen.err));
        if (seen.raised !== want.raised)
            log_mismatch("raised_at_ms",   64'(want.raised), 64'(seen.raised));
        if (seen.wled   !== want.wled)
            log_mismatch("warning_leds",   64'(want.wled),   64'(seen.wled));
        if (seen.aled   !== want.aled)
            log_mismatch("alarm_leds",     64'(want.aled),   64'(seen.aled));
        if (seen.oe     !== want.oe)
            log_mismatch("output_enables", 64'(want.oe),     64'(seen.oe));
    endtask

    // Slave-side driver: a new request goes out at the falling edge once the
    // previous one has been taken; random gaps leave tvalid low between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                on_wire = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, on_wire.now, on_wire.code, on_wire.smp, on_wire.chan};
                s_axis_tuser  <= on_wire.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Master-side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Prediction on each accepted request, checking on each accepted result.
    // Both handshakes are sampled at the rising edge, before the DUT's own updates land.
    always @(posedge i_clk) begin : scoreboard
        t_alarm_result seen;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(resolve_request(on_wire));
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                seen.ok     = m_axis_tuser[0];
                seen.level  = m_axis_tdata[1:0];
                seen.active = m_axis_tdata[2];
                seen.acked  = m_axis_tdata[3];
                seen.err    = m_axis_tdata[11:4];
                seen.raised = m_axis_tdata[43:12];
                seen.wled   = m_axis_tdata[47:44];
                seen.aled   = m_axis_tdata[51:48];
                seen.oe     = m_axis_tdata[55:52];
                if (expected_results.size() == 0)
                    log_mismatch("result with no request outstanding", '0,
                                 64'({m_axis_tuser, m_axis_tdata}));
                else
                    compare_result(seen, expected_results.pop_front());
            end
        end
    end

    task automatic add_item(t_req kind, logic [2:0] chan, logic [15:0] smp,
                            logic [7:0] code, logic [31:0] now);
        t_req_item it;
        it.kind = kind;
        it.chan = chan;
        it.smp  = smp;
        it.code = code;
        it.now  = now;
        pending_requests.push_back(it);
    endtask

    // Uniform value in [lo, hi] as a 16-bit word; an empty range gives any value
    function automatic logic [15:0] pick_in(int lo, int hi);
        if (lo > hi)
            return 16'($urandom);
        return 16'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // Sample aimed at the channel's bands so that raises and drops both happen often
    function automatic logic [15:0] aimed_sample(logic [2:0] chan);
        int al, ah, wl, wh, ch;
        ch = int'(chan[1:0]);
        al = int'(lane_of(alarm_lo_w, ch));
        ah = int'(lane_of(alarm_hi_w, ch));
        wl = int'(lane_of(warn_lo_w, ch));
        wh = int'(lane_of(warn_hi_w, ch));
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'(al);
                    1: return 16'(ah);
                    2: return 16'(wl);
                    default: return 16'(wh);
                endcase
            end
            1, 2: return pick_in(wl + 1, wh - 1);
            3, 4: return $urandom_range(1) ? pick_in(al + 1, wl) : pick_in(wh, ah - 1);
            5, 6: return $urandom_range(1) ? pick_in(-32768, al) : pick_in(ah, 32767);
            7: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random request; runs of requests tend to stay on one channel so that
    // raise, drop, technical and acknowledge sequences build up per channel.
    task automatic add_random_item();
        t_req kind;
        logic [2:0] chan;
        logic [31:0] now;
        int pick;
        if ($urandom_range(99) < 30)
            focus_chan = 3'($urandom_range(3));
        chan = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 4)) : focus_chan;
        pick = $urandom_range(99);
        if (pick < 55)
            kind = REQ_SAMPLE;
        else if (pick < 68)
            kind = REQ_SET_TECH;
        else if (pick < 82)
            kind = REQ_CLR_TECH;
        else
            kind = REQ_ACK;
        ms_clock = ms_clock + $urandom_range(50);
        now = ($urandom_range(19) == 0) ? $urandom : ms_clock;
        add_item(kind, chan, aimed_sample(chan), 8'($urandom_range(255)), now);
    endtask

    // One configuration transaction; valid is left high for a following write
    task automatic cfg_transaction(t_cfg_reg idx, logic [63:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ENABLE:   en_mask    = d[3:0];
            CFG_AUTO_RST: auto_mask  = d[3:0];
            CFG_ALARM_LO: alarm_lo_w = d;
            CFG_ALARM_HI: alarm_hi_w = d;
            CFG_WARN_LO:  warn_lo_w  = d;
            CFG_WARN_HI:  warn_hi_w  = d;
            default: ;
        endcase
    endtask

    task automatic write_config(logic [3:0] en, logic [3:0] au, logic [63:0] alo,
                                logic [63:0] ahi, logic [63:0] wlo, logic [63:0] whi);
        cfg_transaction(CFG_ENABLE,   {60'b0, en});
        cfg_transaction(CFG_AUTO_RST, {60'b0, au});
        cfg_transaction(CFG_ALARM_LO, alo);
        cfg_transaction(CFG_ALARM_HI, ahi);
        cfg_transaction(CFG_WARN_LO,  wlo);
        cfg_transaction(CFG_WARN_HI,  whi);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Every request yields a result, so an empty expectation queue means idle
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int c, w1, w2;
        logic [3:0]  en, au;
        logic [63:0] alo, ahi, wlo, whi;

        en_mask    = '0;
        auto_mask  = '0;
        alarm_lo_w = '0;
        alarm_hi_w = '0;
        warn_lo_w  = '0;
        warn_hi_w  = '0;
        for (int i = 0; i < 4; i++) begin
            chan_level[i]  = LVL_NONE;
            chan_error[i]  = '0;
            chan_raised[i] = '0;
            chan_active[i] = 1'b0;
            chan_acked[i]  = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // First idling mode: light sender gaps, heavy receiver stalls
        send_gap_pct   = 10;
        recv_stall_pct = 55;

        // Directed part. Bands -20 / -10 / 40 / 50 on every channel,
        // channels 0 and 2 auto reset, channel 3 disabled.
        write_config(4'b0111, 4'b0101, {4{16'hEC00}}, {4{16'h3200}},
                     {4{16'hF600}}, {4{16'h2800}});
        add_item(REQ_SAMPLE,   3'd0, 16'h0000, 8'h00, 32'd0);          // inside the bands
        add_item(REQ_SAMPLE,   3'd0, 16'h2800, 8'h00, 32'd10);         // on upper warning limit
        add_item(REQ_SAMPLE,   3'd0, 16'h7FFF, 8'h00, 32'hFFFF_FFFF);  // most positive sample
        add_item(REQ_SAMPLE,   3'd0, 16'h0000, 8'h00, 32'd30);         // auto reset drop
        add_item(REQ_SAMPLE,   3'd1, 16'h8000, 8'h00, 32'd40);         // most negative sample
        add_item(REQ_SAMPLE,   3'd1, 16'h0100, 8'h00, 32'd50);         // manual: drop ignored
        add_item(REQ_ACK,      3'd1, 16'h0000, 8'h00, 32'd55);         // ack while still active
        add_item(REQ_SET_TECH, 3'd1, 16'h0000, 8'hFF, 32'd60);
        add_item(REQ_CLR_TECH, 3'd1, 16'h0000, 8'h00, 32'd62);         // manual: level kept
        add_item(REQ_ACK,      3'd1, 16'h0000, 8'h00, 32'd64);         // manual: back to none
        add_item(REQ_SET_TECH, 3'd0, 16'h0000, 8'h00, 32'd70);         // fault code zero
        add_item(REQ_ACK,      3'd0, 16'h0000, 8'h00, 32'd72);
        add_item(REQ_CLR_TECH, 3'd0, 16'h0000, 8'h00, 32'd74);         // auto: back to none
        add_item(REQ_CLR_TECH, 3'd2, 16'h0000, 8'h00, 32'd76);         // no technical alarm
        add_item(REQ_SAMPLE,   3'd2, 16'hF600, 8'h00, 32'd78);         // on lower warning limit
        add_item(REQ_SAMPLE,   3'd2, 16'hEC00, 8'h00, 32'd80);         // on lower alarm limit
        add_item(REQ_SAMPLE,   3'd2, 16'hF601, 8'h00, 32'd82);         // just inside
        add_item(REQ_SAMPLE,   3'd3, 16'h7FFF, 8'h00, 32'd84);         // channel disabled
        add_item(REQ_SET_TECH, 3'd3, 16'h0000, 8'h5A, 32'd86);
        add_item(REQ_SAMPLE,   3'd4, 16'h8000, 8'hFF, 32'd88);         // index out of range
        add_item(REQ_SET_TECH, 3'd7, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        add_item(REQ_ACK,      3'd5, 16'h0000, 8'h00, 32'd90);
        add_item(REQ_CLR_TECH, 3'd6, 16'h0000, 8'h00, 32'd92);
        add_item(REQ_SAMPLE,   3'd0, 16'h3200, 8'h00, 32'd94);         // on upper alarm limit
        add_item(REQ_SAMPLE,   3'd0, 16'h31FF, 8'h00, 32'd96);         // auto drop to warning
        ms_clock = 32'd100;

        // Random part: twelve settings, four per idling mode
        for (int k = 0; k < 12; k++) begin
            wait_drained();
            if (k == 4) begin
                send_gap_pct   = 55;
                recv_stall_pct = 10;
            end else if (k == 8) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (k)
                0: write_config(4'h0, 4'h0, '0, '0, '0, '0);   // all cleared
                5: write_config(4'hF, 4'hF, {4{16'h8000}}, {4{16'h7FFF}},
                                {4{16'h8000}}, {4{16'h7FFF}});  // widest bands
                9: write_config(4'hF, 4'h0, '1, '1, '1, '1);   // all limits at -1/256
                default: begin
                    en = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'hF;
                    au = 4'($urandom_range(15));
                    // Nested bands around a random centre per channel
                    for (int l = 0; l < 4; l++) begin
                        c  = int'($urandom_range(40000)) - 20000;
                        w1 = $urandom_range(3000, 1);
                        w2 = $urandom_range(3000, 1);
                        alo[16*l +: 16] = 16'(c - w1 - w2);
                        wlo[16*l +: 16] = 16'(c - w1);
                        whi[16*l +: 16] = 16'(c + w1);
                        ahi[16*l +: 16] = 16'(c + w1 + w2);
                    end
                    // now and then a limit word with no ordering at all
                    if ($urandom_range(5) == 0) alo = {$urandom, $urandom};
                    if ($urandom_range(5) == 0) whi = {$urandom, $urandom};
                    write_config(en, au, alo, ahi, wlo, whi);
                end
            endcase
            for (int n = 0; n < 105; n++)
                add_random_item();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        while (expected_results.size() != 0)
            log_mismatch("result never arrived", '0, 64'(expected_results.pop_front()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
